FILE: rtl/ffda_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffda_pkg
// Shared widths, command and status codes, and the control/status bundles
// that join the controller and the datapath of the flux accumulator.
// ----------------------------------------------------------------------------
package ffda_pkg;

	localparam int MAX_CELLS_DEF = 1024;
	localparam int SUM_BITS_DEF  = 40;

	localparam int CMD_W      = 3;
	localparam int CELL_W     = 10;
	localparam int FLUX_W     = 32;
	localparam int OUT_W      = 40;
	localparam int STAT_W     = 2;
	localparam int CFG_W      = 11;
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;
	localparam int CELL_SPAN  = 1 << CELL_W;

	localparam logic [CMD_W-1:0] CMD_CLR_ALL   = 3'd0;
	localparam logic [CMD_W-1:0] CMD_CLR_GHOST = 3'd1;
	localparam logic [CMD_W-1:0] CMD_INTERIOR  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_BOUNDARY  = 3'd3;
	localparam logic [CMD_W-1:0] CMD_READ      = 3'd4;

	localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STAT_W-1:0] STAT_RANGE = 2'd1;
	localparam logic [STAT_W-1:0] STAT_SAT   = 2'd2;

	localparam logic REG_REAL_CELLS  = 1'b0;
	localparam logic REG_TOTAL_CELLS = 1'b1;

	typedef struct packed {
		logic latch;      // capture the accepted beat
		logic clr_step;   // zero one entry of the sweep
		logic wr_a;       // write back cell_a, flux added
		logic wr_b;       // write back cell_b, flux subtracted
		logic rd_b;       // read port addresses cell_b
		logic rd_capture; // clamp and keep the read sum
		logic out_load;   // move the result into the output register
	} ffda_ctl_t;

	typedef struct packed {
		logic a_oor;
		logic b_oor;
		logic clr_empty;
		logic clr_last;
	} ffda_sts_t;

endpackage

FILE: rtl/ffda_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffda_regs
// APB register file: real_cells at 0x0, total_cells at 0x4.
// ----------------------------------------------------------------------------
module ffda_regs
	import ffda_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic [CFG_W-1:0]      real_cells,
	output logic [CFG_W-1:0]      total_cells
);

	logic [CFG_W-1:0] real_cells_q;
	logic [CFG_W-1:0] total_cells_q;
	logic             wr_en;

	assign wr_en = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			real_cells_q  <= CFG_W'(CELL_SPAN);
			total_cells_q <= CFG_W'(CELL_SPAN);
		end else if (wr_en) begin
			if (paddr[2] == REG_TOTAL_CELLS) begin
				total_cells_q <= pwdata[CFG_W-1:0];
			end else begin
				real_cells_q <= pwdata[CFG_W-1:0];
			end
		end
	end

	always_comb begin
		if (paddr[2] == REG_TOTAL_CELLS) begin
			prdata = APB_DATA_W'(total_cells_q);
		end else begin
			prdata = APB_DATA_W'(real_cells_q);
		end
	end

	assign real_cells  = real_cells_q;
	assign total_cells = total_cells_q;

endmodule

FILE: rtl/ffda_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffda_ctrl
// Sequencer: reset clearing pass, command dispatch, read-modify-write steps
// and the hand-off of each result into the output register.
// ----------------------------------------------------------------------------
module ffda_ctrl
	import ffda_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_valid,
	input  logic [CMD_W-1:0] command,
	output logic             s_ready,
	output logic             m_valid,
	input  logic             m_ready,
	input  ffda_sts_t        sts,
	output ffda_ctl_t        ctl
);

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_CLEAR,
		ST_WR_A,
		ST_WR_B,
		ST_READ,
		ST_FIN
	} state_t;

	state_t state_q;
	state_t state_d;
	state_t disp_state;
	logic   m_valid_q;
	logic   interior_q;
	logic   out_free;
	logic   accept_ok;
	logic   accept;

	always_comb begin
		out_free  = !m_valid_q || m_ready;
		accept_ok = (state_q == ST_IDLE) || ((state_q == ST_FIN) && out_free);
		accept    = s_valid && accept_ok;

		case (command)
			CMD_CLR_ALL, CMD_CLR_GHOST: begin
				disp_state = sts.clr_empty ? ST_FIN : ST_CLEAR;
			end
			CMD_INTERIOR: begin
				disp_state = (sts.a_oor || sts.b_oor) ? ST_FIN : ST_WR_A;
			end
			CMD_BOUNDARY: begin
				disp_state = sts.a_oor ? ST_FIN : ST_WR_A;
			end
			CMD_READ: begin
				disp_state = sts.a_oor ? ST_FIN : ST_READ;
			end
			default: begin
				disp_state = ST_FIN;
			end
		endcase

		ctl       = '0;
		ctl.latch = accept;
		state_d   = state_q;
		case (state_q)
			ST_INIT: begin
				ctl.clr_step = 1'b1;
				if (sts.clr_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (accept) state_d = disp_state;
			end
			ST_CLEAR: begin
				ctl.clr_step = 1'b1;
				if (sts.clr_last) state_d = ST_FIN;
			end
			ST_WR_A: begin
				ctl.wr_a = 1'b1;
				ctl.rd_b = 1'b1;
				state_d  = interior_q ? ST_WR_B : ST_FIN;
			end
			ST_WR_B: begin
				ctl.wr_b = 1'b1;
				state_d  = ST_FIN;
			end
			ST_READ: begin
				ctl.rd_capture = 1'b1;
				state_d        = ST_FIN;
			end
			ST_FIN: begin
				// result leaves while the next beat may already be taken
				if (out_free) begin
					ctl.out_load = 1'b1;
					state_d      = accept ? disp_state : ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_INIT;
			m_valid_q  <= 1'b0;
			interior_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_ready) begin
				m_valid_q <= 1'b0;
			end
			if (accept) interior_q <= (command == CMD_INTERIOR);
		end
	end

	assign s_ready = accept_ok;
	assign m_valid = m_valid_q;

endmodule

FILE: rtl/ffda_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffda_dp
// Datapath: cell sum memory, saturating adder, sweep counter for clears,
// range checks, read clamp and the output register.
// ----------------------------------------------------------------------------
module ffda_dp
	import ffda_pkg::*;
#(
	parameter int MAX_CELLS = MAX_CELLS_DEF,
	parameter int SUM_BITS  = SUM_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  ffda_ctl_t                ctl,
	output ffda_sts_t                sts,
	input  logic [CMD_W-1:0]         in_command,
	input  logic [CELL_W-1:0]        in_cell_a,
	input  logic [CELL_W-1:0]        in_cell_b,
	input  logic signed [FLUX_W-1:0] in_flux,
	input  logic [CFG_W-1:0]         real_cells,
	input  logic [CFG_W-1:0]         total_cells,
	output logic [OUT_W-1:0]         out_value,
	output logic [STAT_W-1:0]        out_status
);

	// cell indices are CELL_W bits, so no entry above CELL_SPAN is ever reached
	localparam int DEPTH   = (MAX_CELLS < CELL_SPAN) ? MAX_CELLS : CELL_SPAN;
	localparam int AW      = $clog2(DEPTH);
	localparam int DELTA_W = FLUX_W + 1;
	localparam int XW      = (SUM_BITS > OUT_W) ? SUM_BITS : OUT_W;
	localparam logic signed [XW-1:0] OUT_MAX =
		{{(XW-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}};
	localparam logic signed [XW-1:0] OUT_MIN = ~OUT_MAX;

	logic [SUM_BITS-1:0] mem [DEPTH];
	logic [SUM_BITS-1:0] rdata_q;

	logic [CELL_W-1:0]        a_q;
	logic [CELL_W-1:0]        b_q;
	logic signed [FLUX_W-1:0] flux_q;
	logic [SUM_BITS-1:0]      sum_a_q;
	logic [STAT_W-1:0]        status_q;
	logic [OUT_W-1:0]         value_q;
	logic [OUT_W-1:0]         out_value_q;
	logic [STAT_W-1:0]        out_status_q;
	logic [CFG_W-1:0]         clr_idx_q;
	logic [CFG_W-1:0]         clr_end_q;

	logic [CFG_W-1:0]    lim;
	logic                range_err;
	logic [DELTA_W-1:0]  d_pos;
	logic [DELTA_W-1:0]  d_neg;
	logic [SUM_BITS:0]   add_a;
	logic [SUM_BITS:0]   add_b;
	logic [SUM_BITS-1:0] old_b;
	logic                wr_en;
	logic [AW-1:0]       wr_addr;
	logic [SUM_BITS-1:0] wr_data;
	logic [AW-1:0]       rd_addr;
	logic signed [XW-1:0] rd_ext;
	logic [OUT_W-1:0]    rd_clamped;

	// returns {saturated, sum}
	function automatic logic [SUM_BITS:0] sat_add(input logic [SUM_BITS-1:0] v,
		input logic [DELTA_W-1:0] d);
		logic [SUM_BITS:0] s;
		logic [SUM_BITS:0] r;
		s = {v[SUM_BITS-1], v} + {{(SUM_BITS+1-DELTA_W){d[DELTA_W-1]}}, d};
		if (s[SUM_BITS] != s[SUM_BITS-1]) begin
			r = {1'b1, s[SUM_BITS], {(SUM_BITS-1){~s[SUM_BITS]}}};
		end else begin
			r = {1'b0, s[SUM_BITS-1:0]};
		end
		return r;
	endfunction

	always_comb begin
		lim = (total_cells < CFG_W'(DEPTH)) ? total_cells : CFG_W'(DEPTH);

		sts.a_oor    = CFG_W'(in_cell_a) >= lim;
		sts.b_oor    = CFG_W'(in_cell_b) >= lim;
		sts.clr_last = (clr_idx_q + CFG_W'(1)) == clr_end_q;
		if (in_command == CMD_CLR_ALL) begin
			sts.clr_empty = (lim == '0);
		end else begin
			sts.clr_empty = (real_cells >= lim);
		end

		case (in_command)
			CMD_INTERIOR: range_err = sts.a_oor || sts.b_oor;
			CMD_BOUNDARY, CMD_READ: range_err = sts.a_oor;
			default: range_err = 1'b0;
		endcase

		d_pos = {flux_q[FLUX_W-1], flux_q};
		d_neg = DELTA_W'(0) - d_pos;
		add_a = sat_add(rdata_q, d_pos);
		// read of cell_b returns the value from before the cell_a write
		old_b = (b_q == a_q) ? sum_a_q : rdata_q;
		add_b = sat_add(old_b, d_neg);

		wr_en   = ctl.clr_step || ctl.wr_a || ctl.wr_b;
		wr_addr = clr_idx_q[AW-1:0];
		wr_data = '0;
		if (ctl.wr_a) begin
			wr_addr = a_q[AW-1:0];
			wr_data = add_a[SUM_BITS-1:0];
		end else if (ctl.wr_b) begin
			wr_addr = b_q[AW-1:0];
			wr_data = add_b[SUM_BITS-1:0];
		end

		rd_addr = ctl.rd_b ? b_q[AW-1:0] : in_cell_a[AW-1:0];

		rd_ext = XW'($signed(rdata_q));
		if (rd_ext > OUT_MAX) begin
			rd_clamped = OUT_MAX[OUT_W-1:0];
		end else if (rd_ext < OUT_MIN) begin
			rd_clamped = OUT_MIN[OUT_W-1:0];
		end else begin
			rd_clamped = rd_ext[OUT_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		rdata_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_idx_q <= '0;
			clr_end_q <= CFG_W'(DEPTH);
		end else if (ctl.latch) begin
			clr_idx_q <= (in_command == CMD_CLR_GHOST) ? real_cells : '0;
			clr_end_q <= lim;
		end else if (ctl.clr_step) begin
			clr_idx_q <= clr_idx_q + CFG_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.latch) begin
			a_q          <= in_cell_a;
			b_q          <= in_cell_b;
			flux_q       <= in_flux;
			status_q     <= range_err ? STAT_RANGE : STAT_OK;
			value_q      <= '0;
		end else begin
			if (ctl.wr_a) begin
				sum_a_q <= add_a[SUM_BITS-1:0];
				if (add_a[SUM_BITS]) status_q <= STAT_SAT;
			end
			if (ctl.wr_b && add_b[SUM_BITS]) status_q <= STAT_SAT;
			if (ctl.rd_capture) value_q <= rd_clamped;
		end
		if (ctl.out_load) begin
			out_value_q  <= value_q;
			out_status_q <= status_q;
		end
	end

	assign out_value  = out_value_q;
	assign out_status = out_status_q;

endmodule

FILE: rtl/face_flux_divergence_accumulator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// face_flux_divergence_accumulator
// Per-cell signed flux sums with face scatter-add, clears and reads.
// ----------------------------------------------------------------------------
// Usage: one command beat enters on s_axis (command in tuser, cell_a,
// cell_b and Q16.16 flux in tdata); exactly one result beat leaves on m_axis
// (Q24.16 cell_value in tdata, status in tuser). real_cells and total_cells
// are set over APB while no command is in flight.
// Sequence: a command that touches nothing goes straight to ST_FIN, boundary
// faces pass ST_WR_A, reads ST_READ, interior faces ST_WR_A then ST_WR_B,
// and clears zero each cell in ST_CLEAR. The pace is set by the single write
// port of the cell memory: each face endpoint is one read-modify-write, reads
// of the memory are registered. In ST_FIN the result moves into the output
// register, which drives m_axis_tvalid, and the next command may be taken
// there while that register is free.
// Reset: all control state clears and a clearing pass zeroes the cell
// memory, min(MAX_CELLS, 1024) entries, with s_axis_tready low.
// Stall: a result waits in the output register; the next command is taken
// and processed meanwhile, and its result holds until that register frees.
// ----------------------------------------------------------------------------
module face_flux_divergence_accumulator
	import ffda_pkg::*;
#(
	parameter int MAX_CELLS = MAX_CELLS_DEF,
	parameter int SUM_BITS  = SUM_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// APB configuration
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	// command stream
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [55:0]           s_axis_tdata,  // cell_a[9:0], cell_b[19:10], flux[51:20]
	input  logic [CMD_W-1:0]      s_axis_tuser,  // command[2:0]
	// result stream
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [OUT_W-1:0]      m_axis_tdata,  // cell_value[39:0]
	output logic [STAT_W-1:0]     m_axis_tuser   // status[1:0]
);

	ffda_ctl_t                ctl;
	ffda_sts_t                sts;
	logic [CFG_W-1:0]         real_cells;
	logic [CFG_W-1:0]         total_cells;
	logic signed [FLUX_W-1:0] in_flux;

	assign pready  = 1'b1;
	assign in_flux = $signed(s_axis_tdata[51:20]);

	ffda_regs u_regs (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.real_cells  (real_cells),
		.total_cells (total_cells)
	);

	ffda_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_valid (s_axis_tvalid),
		.command (s_axis_tuser),
		.s_ready (s_axis_tready),
		.m_valid (m_axis_tvalid),
		.m_ready (m_axis_tready),
		.sts     (sts),
		.ctl     (ctl)
	);

	ffda_dp #(
		.MAX_CELLS (MAX_CELLS),
		.SUM_BITS  (SUM_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.sts         (sts),
		.in_command  (s_axis_tuser),
		.in_cell_a   (s_axis_tdata[9:0]),
		.in_cell_b   (s_axis_tdata[19:10]),
		.in_flux     (in_flux),
		.real_cells  (real_cells),
		.total_cells (total_cells),
		.out_value   (m_axis_tdata),
		.out_status  (m_axis_tuser)
	);

endmodule

FILE: rtl/ffda_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffda_checker
// Port-level checks of the flux accumulator, bound to the top level.
// ----------------------------------------------------------------------------
module ffda_checker
	import ffda_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              s_axis_tready,
	input logic              m_axis_tvalid,
	input logic              m_axis_tready,
	input logic [OUT_W-1:0]  m_axis_tdata,
	input logic [STAT_W-1:0] m_axis_tuser
);

	// the clearing pass keeps commands out right after reset
	a_no_accept_after_reset: assert property (@(posedge clk)
		!arst_n |=> !s_axis_tready)
		else $error("command accepted during the reset clearing pass");

	// range errors and saturation never carry a cell value
	a_value_zero_on_error: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser != STAT_OK) |-> m_axis_tdata == '0)
		else $error("nonzero cell_value with error status");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("stalled result beat changed");

endmodule

bind face_flux_divergence_accumulator ffda_checker u_ffda_checker (.*);
